@@ rtl/maxsat_greedy_flip_engine_core_assert.svh @@
// Assertion macros used by the engine checker.
`ifndef MAXSAT_GREEDY_FLIP_ENGINE_CORE_ASSERT_SVH
`define MAXSAT_GREEDY_FLIP_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define MGFE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define MGFE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Holds in the cycle after any cycle spent in reset.
`define MGFE_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mgfe_pkg.sv @@
`timescale 1ns / 1ps

package mgfe_pkg;

    localparam int ROW_W     = 10;
    localparam int SLOT_W    = 2;
    localparam int VAR_W     = 9;
    localparam int CNT_W     = 11;
    localparam int LEN_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;

    typedef enum logic [1:0] {
        CMD_WRITE_LIT = 2'd0,
        CMD_SET_VAR   = 2'd1,
        CMD_FLIP_VAR  = 2'd2,
        CMD_EVAL      = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLAUSES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAUSE_LEN  = 2'd2;

    localparam logic [VAR_W-1:0] RST_NUM_VARS    = 9'd256;
    localparam logic [CNT_W-1:0] RST_NUM_CLAUSES = 11'd0;
    localparam logic [LEN_W-1:0] RST_CLAUSE_LEN  = 3'd3;

    typedef struct packed {
        t_cmd              command;
        logic [ROW_W-1:0]  clause_index;
        logic [SLOT_W-1:0] literal_slot;
        logic [VAR_W-1:0]  var_index;
        logic              negated;
        logic              bit_value;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] sat_count;
        logic [VAR_W-1:0] best_flip;
        logic [CNT_W-1:0] best_count;
    } t_out_item;

endpackage

@@ rtl/maxsat_greedy_flip_engine_core.sv @@
`timescale 1ns / 1ps
// GSAT greedy-flip engine.
// Input channel (i_in_valid / o_in_ready, payload i_in) takes command items:
// write a clause literal, set a variable, flip a variable, or evaluate.
// Output channel (o_out_valid / i_out_ready, payload o_out) gives one item per
// evaluate: satisfied count, best flip variable (0 if none) and its count.
// Config port (i_cfg_we / i_cfg_idx / i_cfg_wdata) sets num_vars,
// num_clauses and clause_len; write it only while the engine is idle.
// Literal write and set act on acceptance; flip reads, then writes back.
// Evaluate runs up to num_vars+1 passes over the clause store, one literal
// read per cycle from the single store port, before the result is handed
// over; it ends early once every clause is satisfied. No item is taken
// while it runs. After reset all MAX_VARS entries of the assignment memory
// are cleared in a sweep; no item is taken during that sweep. The result
// sits in an output register, so further items are taken while the
// receiver stalls; an evaluate finishing under a stall waits until the
// register frees up.
module maxsat_greedy_flip_engine_core import mgfe_pkg::*; #(
    parameter int MAX_VARS       = 256,
    parameter int MAX_CLAUSES    = 1024,
    parameter int MAX_CLAUSE_LEN = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out
);

    localparam int DEPTH  = MAX_CLAUSES * MAX_CLAUSE_LEN;
    localparam int SA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VIDX_W = $clog2(MAX_VARS);
    localparam int VCMP_W = ((VAR_W > VIDX_W) ? VAR_W : VIDX_W) + 1;
    localparam int ENT_W  = VAR_W + 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FLIP  = 6'b000100,
        S_ISSUE = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic f_var_ok(input logic [VAR_W-1:0] v);
        logic [VCMP_W-1:0] e;
        e = VCMP_W'(v);
        return (e != '0) && (e <= VCMP_W'(MAX_VARS));
    endfunction

    function automatic logic [VIDX_W-1:0] f_var_idx(input logic [VAR_W-1:0] v);
        logic [VCMP_W-1:0] e;
        e = VCMP_W'(v) - VCMP_W'(1);
        return e[VIDX_W-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [VAR_W-1:0]   r_num_vars;
    logic [CNT_W-1:0]   r_num_clauses;
    logic [LEN_W-1:0]   r_clause_len;
    logic [VIDX_W-1:0]  r_clr_idx, n_clr_idx;
    logic [VIDX_W-1:0]  r_flip_idx, n_flip_idx;
    logic [VAR_W-1:0]   r_pass, n_pass;
    logic [CNT_W-1:0]   r_clause, n_clause;
    logic [LEN_W-1:0]   r_slot, n_slot;
    logic [SA_W-1:0]    r_row_base, n_row_base;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_cl_or, n_cl_or;
    logic [CNT_W-1:0]   r_base, n_base;
    logic [CNT_W-1:0]   r_best, n_best;
    logic [VAR_W-1:0]   r_pick, n_pick;
    logic               r_out_vld, n_out_vld;
    t_out_item          r_out, n_out;

    logic               r_s1_vld, r_s1_end_cl, r_s1_end_pass;
    logic               r_s2_vld, r_s2_end_cl, r_s2_end_pass;
    logic [VAR_W-1:0]   r_s2_var;
    logic               r_s2_neg, r_s2_ok;

    logic [ENT_W-1:0]   r_store_mem [DEPTH];
    logic [ENT_W-1:0]   r_store_q;
    logic               r_asg_mem [MAX_VARS];
    logic               r_asg_q;

    logic [VAR_W-1:0]   w_nv;
    logic [CNT_W-1:0]   w_nc;
    logic [LEN_W-1:0]   w_len;
    logic               w_in_acc;
    logic               w_st_we;
    logic [SA_W-1:0]    w_st_waddr, w_st_raddr;
    logic               w_asg_we, w_asg_wdata;
    logic [VIDX_W-1:0]  w_asg_waddr, w_asg_raddr;
    logic               w_issue, w_last_slot, w_last_cl;
    logic               w_match, w_lit, w_cl_sat;
    logic [CNT_W-1:0]   w_acc_count;
    logic               w_acc_or;

    assign w_nv  = (32'(r_num_vars) > MAX_VARS) ? VAR_W'(MAX_VARS) : r_num_vars;
    assign w_nc  = (32'(r_num_clauses) > MAX_CLAUSES) ? CNT_W'(MAX_CLAUSES) : r_num_clauses;
    assign w_len = (32'(r_clause_len) > MAX_CLAUSE_LEN) ? LEN_W'(MAX_CLAUSE_LEN)
                                                       : r_clause_len;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // clause store: one literal per entry, row-major
    assign w_st_we    = w_in_acc && (i_in.command == CMD_WRITE_LIT)
                        && (32'(i_in.clause_index) < MAX_CLAUSES)
                        && (32'(i_in.literal_slot) < MAX_CLAUSE_LEN);
    assign w_st_waddr = SA_W'(32'(i_in.clause_index) * MAX_CLAUSE_LEN
                              + 32'(i_in.literal_slot));
    assign w_st_raddr = r_row_base + SA_W'(r_slot);

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_store_mem[w_st_waddr] <= {i_in.negated, i_in.var_index};
        end
        r_store_q <= r_store_mem[w_st_raddr];
    end

    // assignment memory
    always_comb begin
        w_asg_we    = 1'b0;
        w_asg_waddr = r_clr_idx;
        w_asg_wdata = 1'b0;
        if (r_state == S_CLEAR) begin
            w_asg_we = 1'b1;
        end else if (r_state == S_FLIP) begin
            w_asg_we    = 1'b1;
            w_asg_waddr = r_flip_idx;
            w_asg_wdata = ~r_asg_q;
        end else if (w_in_acc && (i_in.command == CMD_SET_VAR)
                     && f_var_ok(i_in.var_index)) begin
            w_asg_we    = 1'b1;
            w_asg_waddr = f_var_idx(i_in.var_index);
            w_asg_wdata = i_in.bit_value;
        end
    end

    assign w_asg_raddr = (r_state == S_IDLE) ? f_var_idx(i_in.var_index)
                                             : f_var_idx(r_store_q[VAR_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_asg_we) begin
            r_asg_mem[w_asg_waddr] <= w_asg_wdata;
        end
        r_asg_q <= r_asg_mem[w_asg_raddr];
    end

    // literal pipeline: issue, store read, assignment read
    assign w_issue     = (r_state == S_ISSUE);
    assign w_last_slot = (r_slot == w_len - LEN_W'(1));
    assign w_last_cl   = (r_clause == w_nc - CNT_W'(1));

    assign w_match  = (r_s2_var == r_pass);
    assign w_lit    = (r_s2_ok & (r_asg_q ^ w_match)) ^ r_s2_neg;
    assign w_cl_sat = r_cl_or | w_lit;

    always_comb begin
        w_acc_count = r_count;
        w_acc_or    = r_cl_or;
        if (r_s2_vld) begin
            if (r_s2_end_cl) begin
                w_acc_or = 1'b0;
                if (w_cl_sat) begin
                    w_acc_count = r_count + CNT_W'(1);
                end
            end else begin
                w_acc_or = w_cl_sat;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_flip_idx = r_flip_idx;
        n_pass     = r_pass;
        n_clause   = r_clause;
        n_slot     = r_slot;
        n_row_base = r_row_base;
        n_count    = w_acc_count;
        n_cl_or    = w_acc_or;
        n_base     = r_base;
        n_best     = r_best;
        n_pick     = r_pick;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + VIDX_W'(1);
                if (r_clr_idx == VIDX_W'(MAX_VARS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in.command)
                        CMD_FLIP_VAR: begin
                            if (f_var_ok(i_in.var_index)) begin
                                n_flip_idx = f_var_idx(i_in.var_index);
                                n_state    = S_FLIP;
                            end
                        end
                        CMD_EVAL: begin
                            n_pass     = '0;
                            n_clause   = '0;
                            n_slot     = '0;
                            n_row_base = '0;
                            n_count    = '0;
                            n_cl_or    = 1'b0;
                            if ((w_nc == '0) || (w_len == '0)) begin
                                n_base  = '0;
                                n_best  = '0;
                                n_pick  = '0;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FLIP: begin
                n_state = S_IDLE;
            end
            S_ISSUE: begin
                if (w_last_slot) begin
                    n_slot     = '0;
                    n_clause   = r_clause + CNT_W'(1);
                    n_row_base = r_row_base + SA_W'(MAX_CLAUSE_LEN);
                    if (w_last_cl) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_slot = r_slot + LEN_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_s2_vld && r_s2_end_pass) begin
                    if (r_pass == '0) begin
                        n_base = w_acc_count;
                        n_best = w_acc_count;
                        n_pick = '0;
                    end else if (w_acc_count > r_best) begin
                        n_best = w_acc_count;
                        n_pick = r_pass;
                    end
                    if ((r_pass == w_nv) || (n_best == w_nc)) begin
                        n_state = S_DONE;
                    end else begin
                        n_pass     = r_pass + VAR_W'(1);
                        n_clause   = '0;
                        n_slot     = '0;
                        n_row_base = '0;
                        n_count    = '0;
                        n_cl_or    = 1'b0;
                        n_state    = S_ISSUE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld        = 1'b1;
                    n_out.sat_count  = r_base;
                    n_out.best_flip  = r_pick;
                    n_out.best_count = r_best;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_out_vld     <= 1'b0;
            r_s1_vld      <= 1'b0;
            r_s2_vld      <= 1'b0;
            r_num_vars    <= RST_NUM_VARS;
            r_num_clauses <= RST_NUM_CLAUSES;
            r_clause_len  <= RST_CLAUSE_LEN;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_out_vld <= n_out_vld;
            r_s1_vld  <= w_issue;
            r_s2_vld  <= r_s1_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NUM_VARS:    r_num_vars    <= i_cfg_wdata[VAR_W-1:0];
                    REG_NUM_CLAUSES: r_num_clauses <= i_cfg_wdata[CNT_W-1:0];
                    REG_CLAUSE_LEN:  r_clause_len  <= i_cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flip_idx    <= n_flip_idx;
        r_pass        <= n_pass;
        r_clause      <= n_clause;
        r_slot        <= n_slot;
        r_row_base    <= n_row_base;
        r_count       <= n_count;
        r_cl_or       <= n_cl_or;
        r_base        <= n_base;
        r_best        <= n_best;
        r_pick        <= n_pick;
        r_out         <= n_out;
        r_s1_end_cl   <= w_last_slot;
        r_s1_end_pass <= w_last_slot && w_last_cl;
        r_s2_end_cl   <= r_s1_end_cl;
        r_s2_end_pass <= r_s1_end_pass;
        r_s2_var      <= r_store_q[VAR_W-1:0];
        r_s2_neg      <= r_store_q[VAR_W];
        r_s2_ok       <= f_var_ok(r_store_q[VAR_W-1:0]);
    end

endmodule

@@ rtl/mgfe_checker.sv @@
`timescale 1ns / 1ps
`include "maxsat_greedy_flip_engine_core_assert.svh"

module mgfe_checker import mgfe_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    `MGFE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result item dropped under stall")
    `MGFE_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out), "result item changed under stall")
    `MGFE_ASSERT_IMP(a_pick_none, i_clk, i_rst_n, o_out_valid, (o_out.best_flip == '0) == (o_out.best_count == o_out.sat_count), "best flip and counts disagree")
    `MGFE_ASSERT_NXT(a_eval_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in.command == CMD_EVAL), !o_in_ready, "item taken right after evaluate")
    `MGFE_ASSERT_RST(a_clear_busy, i_clk, i_rst_n, !o_in_ready, "item taken before clear sweep")

endmodule

bind maxsat_greedy_flip_engine_core mgfe_checker u_mgfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
